### rtl/core/c1ks_pkg.sv
// shared types and constants of the crypto1 keystream unit
`default_nettype none

package c1ks_pkg;

  localparam int unsigned HALF_W = 24;
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 2;

  localparam logic [OP_W-1:0] OP_RELOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
  localparam logic [OP_W-1:0] OP_WORD   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic [HALF_W-1:0] odd_half;
    logic [HALF_W-1:0] even_half;
  } lfsr_state_t;

endpackage

`default_nettype wire

### rtl/core/c1ks_lfsr.sv
// combinational lfsr advance and filter for one request
`default_nettype none

module c1ks_lfsr (
  input  c1ks_pkg::lfsr_state_t          state_i,
  input  logic [c1ks_pkg::OP_W-1:0]      op_i,
  input  logic [c1ks_pkg::DATA_W-1:0]    data_i,
  input  logic [c1ks_pkg::KEY_W-1:0]     key_i,
  output c1ks_pkg::lfsr_state_t          state_o,
  output logic [c1ks_pkg::DATA_W-1:0]    keystream_o
);

  localparam logic [c1ks_pkg::HALF_W-1:0] TAPS_ODD  = 24'h29ce5c;
  localparam logic [c1ks_pkg::HALF_W-1:0] TAPS_EVEN = 24'h870804;
  localparam logic [19:0] FILT_A   = 20'hf22c0;
  localparam logic [19:0] FILT_B   = 20'h6c9c0;
  localparam logic [19:0] FILT_C   = 20'h3c8b0;
  localparam logic [19:0] FILT_D   = 20'h1e458;
  localparam logic [19:0] FILT_E   = 20'h0d938;
  localparam logic [31:0] FILT_OUT = 32'hec57e80a;

  function automatic logic filter_bit(input logic [c1ks_pkg::HALF_W-1:0] v);
    logic [19:0] ta, tb, tc, td, te;
    logic [4:0]  idx;
    ta  = FILT_A >> v[3:0];
    tb  = FILT_B >> v[7:4];
    tc  = FILT_C >> v[11:8];
    td  = FILT_D >> v[15:12];
    te  = FILT_E >> v[19:16];
    idx = {ta[4], tb[3], tc[2], td[1], te[0]};
    return FILT_OUT[idx];
  endfunction

  // one lfsr clock: feedback into even, then the halves swap roles
  function automatic c1ks_pkg::lfsr_state_t clock_once(input c1ks_pkg::lfsr_state_t s,
                                                       input logic in_bit);
    c1ks_pkg::lfsr_state_t r;
    logic fb;
    fb          = in_bit ^ (^(s.odd_half & TAPS_ODD)) ^ (^(s.even_half & TAPS_EVEN));
    r.even_half = s.odd_half;
    r.odd_half  = {s.even_half[c1ks_pkg::HALF_W-2:0], fb};
    return r;
  endfunction

  c1ks_pkg::lfsr_state_t        st;
  logic [c1ks_pkg::DATA_W-1:0]  ks;
  logic [4:0]                   pos;

  always_comb begin
    st  = state_i;
    ks  = '0;
    pos = '0;
    case (op_i)
      c1ks_pkg::OP_RELOAD: begin
        // key bits interleave into the halves, bit order reversed within each key byte
        for (int j = 0; j < c1ks_pkg::HALF_W; j++) begin
          st.odd_half[j]  = key_i[6'(2*j) ^ 6'd7];
          st.even_half[j] = key_i[6'(2*j+1) ^ 6'd7];
        end
      end
      c1ks_pkg::OP_BYTE: begin
        for (int i = 0; i < 8; i++) begin
          ks[i] = filter_bit(st.odd_half);
          st    = clock_once(st, data_i[i]);
        end
      end
      c1ks_pkg::OP_WORD: begin
        // bytes from most significant down, each lsb first
        for (int i = 0; i < c1ks_pkg::DATA_W; i++) begin
          pos     = 5'(i) ^ 5'd24;
          ks[pos] = filter_bit(st.odd_half);
          st      = clock_once(st, data_i[pos]);
        end
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  assign state_o     = st;
  assign keystream_o = ks;

endmodule

`default_nettype wire

### rtl/core/crypto1_keystream_unit.sv
// top level of the crypto1 keystream unit
`default_nettype none

// Crypto1 keystream engine. A request carries an op (0 reload from the key register, 1 byte
// step on data_in_i[7:0], 2 word step on all 32 bits, bytes 3..0 each lsb first) and returns
// one keystream word with each filter bit at the position of the input bit it came with;
// reload and op 3 return zero. One request is taken every cycle while the result side does
// not stall; a request is captured in an input register at the accepting edge, and the lfsr
// advance of up to 32 steps then updates the cipher state and the result register together
// once the result register is free, which presents the result. The key register is
// written through the cfg channel, which is always ready, and takes effect on the next reload.
module crypto1_keystream_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [c1ks_pkg::KEY_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [c1ks_pkg::OP_W-1:0]      op_i,
  input  logic [c1ks_pkg::DATA_W-1:0]    data_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [c1ks_pkg::DATA_W-1:0]    keystream_o
);

  logic [c1ks_pkg::KEY_W-1:0]  key_q;
  logic                        in_valid_q;
  logic [c1ks_pkg::OP_W-1:0]   op_q;
  logic [c1ks_pkg::DATA_W-1:0] data_q;
  logic                        out_valid_q;
  logic [c1ks_pkg::DATA_W-1:0] ks_q;
  c1ks_pkg::lfsr_state_t       state_q, state_d;
  logic [c1ks_pkg::DATA_W-1:0] ks_d;
  logic                        res_free, advance, in_accept;

  assign cfg_ready_o = 1'b1;
  assign res_free    = ~out_valid_q | ~out_stall_i;
  assign advance     = in_valid_q & res_free;
  assign in_stall_o  = in_valid_q & ~res_free;
  assign in_accept   = in_valid_i & ~in_stall_o;

  c1ks_lfsr u_lfsr (
    .state_i     (state_q),
    .op_i        (op_q),
    .data_i      (data_q),
    .key_i       (key_q),
    .state_o     (state_d),
    .keystream_o (ks_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      state_q     <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        key_q <= cfg_data_i;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_i;
      data_q <= data_in_i;
    end
    if (advance) begin
      ks_q <= ks_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign keystream_o = ks_q;

  a_zero_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (op_q == c1ks_pkg::OP_RELOAD || op_q == c1ks_pkg::OP_NONE)
    |=> keystream_o == '0)
    else $error("reload or unused op gave non-zero keystream");

  a_byte_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && op_q == c1ks_pkg::OP_BYTE |=> keystream_o[c1ks_pkg::DATA_W-1:8] == '0)
    else $error("byte step set upper keystream bits");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("cipher state moved without a request");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced request produced no result");

endmodule

`default_nettype wire

### bench/tb.sv
// self-checking testbench of the crypto1 keystream unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  class keystream_predictor;
    localparam logic [c1ks_pkg::HALF_W-1:0] TAPS_ODD  = 24'h29ce5c;
    localparam logic [c1ks_pkg::HALF_W-1:0] TAPS_EVEN = 24'h870804;
    localparam logic [19:0]       FILT_A    = 20'hf22c0;
    localparam logic [19:0]       FILT_B    = 20'h6c9c0;
    localparam logic [19:0]       FILT_C    = 20'h3c8b0;
    localparam logic [19:0]       FILT_D    = 20'h1e458;
    localparam logic [19:0]       FILT_E    = 20'h0d938;
    localparam logic [31:0]       FILT_OUT  = 32'hec57e80a;

    logic [c1ks_pkg::KEY_W-1:0]  key;
    logic [c1ks_pkg::HALF_W-1:0] odd_bits;
    logic [c1ks_pkg::HALF_W-1:0] even_bits;
    logic [c1ks_pkg::DATA_W-1:0] expected_ks[$];
    int unsigned                 mismatch_count;

    function new();
      key            = '0;
      odd_bits       = '0;
      even_bits      = '0;
      mismatch_count = 0;
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    function void set_key(input logic [c1ks_pkg::KEY_W-1:0] value);
      key = value;
    endfunction

    function int unsigned pending();
      return expected_ks.size();
    endfunction

    // two-level nonlinear filter over the odd half
    function logic filter_of(input logic [c1ks_pkg::HALF_W-1:0] v);
      logic [4:0] idx;
      idx[4] = FILT_A[int'(v[3:0]) + 4];
      idx[3] = FILT_B[int'(v[7:4]) + 3];
      idx[2] = FILT_C[int'(v[11:8]) + 2];
      idx[1] = FILT_D[int'(v[15:12]) + 1];
      idx[0] = FILT_E[int'(v[19:16])];
      return FILT_OUT[idx];
    endfunction

    function logic clock_step(input logic in_bit);
      logic                        ks;
      logic                        fb;
      logic [c1ks_pkg::HALF_W-1:0] nxt;
      ks        = filter_of(odd_bits);
      fb        = in_bit ^ (^(odd_bits & TAPS_ODD)) ^ (^(even_bits & TAPS_EVEN));
      nxt       = {even_bits[c1ks_pkg::HALF_W-2:0], fb};
      even_bits = odd_bits;
      odd_bits  = nxt;
      return ks;
    endfunction

    // key bits are interleaved into the halves, msb pair first, bytes bit-reversed
    function void load_from_key();
      odd_bits  = '0;
      even_bits = '0;
      for (int pos = 47; pos > 0; pos -= 2) begin
        odd_bits  = {odd_bits[c1ks_pkg::HALF_W-2:0], key[(pos - 1) ^ 7]};
        even_bits = {even_bits[c1ks_pkg::HALF_W-2:0], key[pos ^ 7]};
      end
    endfunction

    function void note_request(input logic [c1ks_pkg::OP_W-1:0] op,
                               input logic [c1ks_pkg::DATA_W-1:0] data);
      logic [c1ks_pkg::DATA_W-1:0] ks;
      int                          p;
      ks = '0;
      case (op)
        c1ks_pkg::OP_RELOAD: load_from_key();
        c1ks_pkg::OP_BYTE: begin
          for (int i = 0; i < 8; i++) ks[i] = clock_step(data[i]);
        end
        c1ks_pkg::OP_WORD: begin
          // bytes from the top down, each lsb first
          for (int i = 0; i < 32; i++) begin
            p     = i ^ 24;
            ks[p] = clock_step(data[p]);
          end
        end
        default: ;
      endcase
      expected_ks.push_back(ks);
    endfunction

    task check_keystream(input logic [c1ks_pkg::DATA_W-1:0] got);
      logic [c1ks_pkg::DATA_W-1:0] want;
      if (expected_ks.size() == 0) begin
        report_mismatch($sformatf("keystream %h with no request outstanding", got));
      end else begin
        want = expected_ks.pop_front();
        if (got !== want)
          report_mismatch($sformatf("keystream %h, predicted %h", got, want));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid   = 1'b0;
  logic [c1ks_pkg::KEY_W-1:0]  cfg_data    = '0;
  logic                        in_valid    = 1'b0;
  logic [c1ks_pkg::OP_W-1:0]   op          = c1ks_pkg::OP_RELOAD;
  logic [c1ks_pkg::DATA_W-1:0] data_in     = '0;
  logic                        out_stall   = 1'b0;
  logic                        cfg_ready;
  logic                        in_stall;
  logic                        out_valid;
  logic [c1ks_pkg::DATA_W-1:0] keystream;

  int unsigned        in_gap_max  = 11;
  int unsigned        out_gap_max = 11;
  keystream_predictor board;

  crypto1_keystream_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (op),
    .data_in_i   (data_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .keystream_o (keystream)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL crypto1_keystream_unit");
    $finish;
  end

  task automatic push_request(input logic [c1ks_pkg::OP_W-1:0] req_op,
                              input logic [c1ks_pkg::DATA_W-1:0] req_data);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= req_op;
    data_in  <= req_data;
    do @(posedge clk); while (in_stall);
    board.note_request(req_op, req_data);
  endtask

  // drop the request line and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_key(input logic [c1ks_pkg::KEY_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.set_key(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall before each result
  initial begin
    int unsigned gap;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_keystream(keystream);
    end
  end

  initial begin
    logic [c1ks_pkg::KEY_W-1:0] key;
    int unsigned                pick;
    board = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // directed: zero state after reset, then key extremes and every op
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_00a5);
    push_request(c1ks_pkg::OP_RELOAD, 32'hffff_ffff);
    wait_idle();
    write_key('1);
    push_request(c1ks_pkg::OP_RELOAD, 32'h0000_0000);
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_0000);
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_00ff);
    push_request(c1ks_pkg::OP_BYTE,   32'hffff_ff00);
    push_request(c1ks_pkg::OP_WORD,   32'h0000_0000);
    push_request(c1ks_pkg::OP_WORD,   32'hffff_ffff);
    push_request(c1ks_pkg::OP_WORD,   32'h0123_4567);
    push_request(c1ks_pkg::OP_NONE,   32'hffff_ffff);
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_003c);
    push_request(c1ks_pkg::OP_RELOAD, 32'h5555_5555);
    push_request(c1ks_pkg::OP_WORD,   32'h89ab_cdef);
    wait_idle();
    write_key('0);
    push_request(c1ks_pkg::OP_RELOAD, 32'h0000_0000);
    push_request(c1ks_pkg::OP_WORD,   32'hffff_ffff);
    push_request(c1ks_pkg::OP_NONE,   32'h0000_0000);
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_00ff);
    wait_idle();
    write_key(48'ha0a1_a2a3_a4a5);
    push_request(c1ks_pkg::OP_RELOAD, 32'h0000_0000);
    push_request(c1ks_pkg::OP_WORD,   32'h8000_0001);
    push_request(c1ks_pkg::OP_BYTE,   32'h0000_0080);
    push_request(c1ks_pkg::OP_WORD,   32'h5a5a_5a5a);

    // random phases, each from a fresh key
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase == 0)      key = '1;
      else if (phase == 7) key = '0;
      else                 key = {16'($urandom), $urandom};
      write_key(key);
      in_gap_max  = (phase % 3 == 1) ? 0 : 11;
      out_gap_max = (phase % 4 == 1) ? 0 : 11;
      push_request(c1ks_pkg::OP_RELOAD, $urandom);
      repeat (210) begin
        pick = $urandom_range(0, 99);
        if (pick < 5)       push_request(c1ks_pkg::OP_RELOAD, $urandom);
        else if (pick < 8)  push_request(c1ks_pkg::OP_NONE, $urandom);
        else if (pick < 50) push_request(c1ks_pkg::OP_BYTE, $urandom);
        else                push_request(c1ks_pkg::OP_WORD, $urandom);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (board.mismatch_count == 0) begin
      $display("PASS crypto1_keystream_unit");
    end else begin
      $display("FAIL crypto1_keystream_unit");
    end
    $finish;
  end

endmodule
